// ===== design/whs_pkg.sv =====
// ----------------------------------------------------------------------------
// whs_pkg: shared types and constants of the weighted histogram sampler
// Beat payload structs, bin table entry, opcodes, status codes and the
// generator constants.
// ----------------------------------------------------------------------------
`default_nettype none

package whs_pkg;

  localparam int VALUE_W   = 32;
  localparam int BIN_IDX_W = 4;
  localparam int WEIGHT_W  = 16;
  localparam int FRAC_W    = 24;   // draw n is a fraction over 2^24

  localparam logic [30:0] LEHMER_MOD   = 31'h7FFF_FFFF;
  localparam logic [14:0] LEHMER_MUL_A = 15'd24112;
  localparam logic [14:0] LEHMER_MUL_B = 15'd26143;

  localparam logic [1:0] OP_APPEND      = 2'd0;
  localparam logic [1:0] OP_SAMPLE_REAL = 2'd1;
  localparam logic [1:0] OP_SAMPLE_ENUM = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [VALUE_W-1:0]  bin_low;
    logic signed [VALUE_W-1:0]  bin_high;
    logic [WEIGHT_W-1:0]        weight;
  } whs_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  value;
    logic [BIN_IDX_W-1:0]       bin_index;
    logic [1:0]                 status;
  } whs_out_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  bin_low;
    logic signed [VALUE_W-1:0]  bin_high;
    logic [WEIGHT_W-1:0]        weight;
  } whs_bin_t;

endpackage

`default_nettype wire

// ===== design/whs_ram.sv =====
// ----------------------------------------------------------------------------
// whs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/weighted_histogram_sampler.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_sampler: weighted bin table with Lehmer-driven sampling
// Appends bins and samples a real value or a bin label from the table.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the beat is taken at an edge where
// busy is low. busy then stays high until the single result beat has been
// shown on out_data with out_valid high for one cycle; the receiver cannot
// stall it. The next start is taken in the cycle after out_valid.
// Append, an empty-table sample and an unused opcode: out_valid in the cycle
// after the accept.
// Enum sample: two generator steps and the total scaling, then a scan of k
// bins (1 up to the bin count) until out_valid; a real sample then runs two
// more generator steps, the in-bin placement, a sum and a value step. One
// shared 33x26 multiplier does both generator steps, the total scaling and
// the in-bin placement; each generator step is followed by a fold cycle. The
// scan walks the bin table RAM read port one bin per cycle.
// cfg_we loads the generator state with cfg_wdata; write it only while idle.
// Reset empties the table (bin count and weight total to zero) and sets the
// generator state to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_sampler #(
  parameter int BINS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire whs_pkg::whs_in_t in_data,
  output logic                  out_valid,
  output whs_pkg::whs_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [30:0]      cfg_wdata
);

  localparam int AW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW  = $clog2(BINS + 1);
  localparam int TW  = whs_pkg::WEIGHT_W + $clog2(BINS);
  localparam int NW  = whs_pkg::FRAC_W + 1;
  localparam int PW  = TW + NW;
  localparam int AMW = 33;
  localparam int BMW = NW + 1;
  localparam int PRW = AMW + BMW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MA   = 11'b000_0000_0010,
    S_RA   = 11'b000_0000_0100,
    S_MB   = 11'b000_0000_1000,
    S_RB   = 11'b000_0001_0000,
    S_MT   = 11'b000_0010_0000,
    S_SCAN = 11'b000_0100_0000,
    S_MD   = 11'b000_1000_0000,
    S_SUM  = 11'b001_0000_0000,
    S_VAL  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [30:0]              gen_r, gen_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [TW-1:0]            total_r, total_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [TW-1:0]            cum_r, cum_nxt;
  logic signed [PRW-1:0]    prod_r, prod_nxt;
  logic signed [31:0]       low_r, low_nxt;
  logic signed [32:0]       diff_r, diff_nxt;
  logic [1:0]               op_r, op_nxt;
  logic                     second_r, second_nxt;
  whs_pkg::whs_out_t        res_r, res_nxt;

  logic                     accept;
  logic                     full;
  logic signed [AMW-1:0]    mul_a;
  logic signed [BMW-1:0]    mul_b;
  logic signed [PRW-1:0]    mul_p;
  logic [31:0]              fold;
  logic [30:0]              reduced;
  logic [NW-1:0]            n_w;
  logic [TW-1:0]            cum_sum;
  logic                     below;
  logic                     last_bin;
  logic signed [PRW-1:0]    num;
  logic                     round_up;

  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  whs_pkg::whs_bin_t        ram_wdata;
  whs_pkg::whs_bin_t        rd;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_FIN);
  assign out_data  = res_r;
  assign full      = (count_r == CW'(BINS));

  assign ram_we    = accept && (in_data.opcode == whs_pkg::OP_APPEND) && !full;
  assign ram_wdata = '{bin_low: in_data.bin_low, bin_high: in_data.bin_high,
                       weight: in_data.weight};

  whs_ram #(
    .WIDTH ($bits(whs_pkg::whs_bin_t)),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MA: begin
        mul_a = AMW'(gen_r);
        mul_b = BMW'(whs_pkg::LEHMER_MUL_A);
      end
      S_MB: begin
        mul_a = AMW'(gen_r);
        mul_b = BMW'(whs_pkg::LEHMER_MUL_B);
      end
      S_MT: begin
        mul_a = AMW'(total_r);
        mul_b = BMW'(n_w);
      end
      S_MD: begin
        mul_a = diff_r;
        mul_b = BMW'(n_w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // fold modulo 2^31-1, one subtract brings it into range
  assign fold    = {1'b0, prod_r[30:0]} + {17'd0, prod_r[45:31]};
  assign reduced = (fold >= {1'b0, whs_pkg::LEHMER_MOD}) ?
                   31'(fold - {1'b0, whs_pkg::LEHMER_MOD}) : fold[30:0];

  assign n_w = {1'b0, gen_r[30:7] | 24'd1} + NW'(1);

  assign cum_sum  = cum_r + TW'(rd.weight);
  assign below    = prod_r[PW-1:0] < {1'b0, cum_sum, {whs_pkg::FRAC_W{1'b0}}};
  assign last_bin = (CW'(idx_r) == (count_r - CW'(1)));

  assign num      = $signed({{(PRW-56){low_r[31]}}, low_r, {whs_pkg::FRAC_W{1'b0}}}) + prod_r;
  // truncate toward zero: negative values with a fraction round up
  assign round_up = prod_r[PRW-1] && (prod_r[whs_pkg::FRAC_W-1:0] != '0);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    case (state_r)
      S_MT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_SCAN: begin
        // hold the read data of a chosen bin
        ram_re    = !(below || last_bin);
        ram_raddr = idx_r + AW'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = idx_r;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    gen_nxt    = gen_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    idx_nxt    = idx_r;
    cum_nxt    = cum_r;
    prod_nxt   = prod_r;
    low_nxt    = low_r;
    diff_nxt   = diff_r;
    op_nxt     = op_r;
    second_nxt = second_r;
    res_nxt    = res_r;

    if (cfg_we) begin
      gen_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_data.opcode;
          idx_nxt    = '0;
          cum_nxt    = '0;
          second_nxt = 1'b0;
          res_nxt    = '0;
          state_nxt  = S_FIN;
          case (in_data.opcode)
            whs_pkg::OP_APPEND: begin
              if (full) begin
                res_nxt.status = whs_pkg::ST_FULL;
              end else begin
                res_nxt.bin_index = whs_pkg::BIN_IDX_W'(count_r);
                count_nxt = count_r + CW'(1);
                total_nxt = total_r + TW'(in_data.weight);
              end
            end
            whs_pkg::OP_SAMPLE_REAL, whs_pkg::OP_SAMPLE_ENUM: begin
              if (count_r == '0) begin
                res_nxt.status = whs_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_MA;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_MA: begin
        prod_nxt  = mul_p;
        state_nxt = S_RA;
      end
      S_RA: begin
        gen_nxt   = reduced;
        state_nxt = S_MB;
      end
      S_MB: begin
        prod_nxt  = mul_p;
        state_nxt = S_RB;
      end
      S_RB: begin
        gen_nxt   = reduced;
        state_nxt = second_r ? S_MD : S_MT;
      end
      S_MT: begin
        prod_nxt  = mul_p;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cum_nxt = cum_sum;
        if (below || last_bin) begin
          low_nxt  = rd.bin_low;
          diff_nxt = $signed({rd.bin_high[31], rd.bin_high}) -
                     $signed({rd.bin_low[31], rd.bin_low});
          res_nxt.bin_index = whs_pkg::BIN_IDX_W'(idx_r);
          res_nxt.status    = whs_pkg::ST_OK;
          if (op_r == whs_pkg::OP_SAMPLE_ENUM) begin
            res_nxt.value = rd.bin_low;
            state_nxt     = S_FIN;
          end else begin
            second_nxt = 1'b1;
            state_nxt  = S_MA;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_MD: begin
        prod_nxt  = mul_p;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        prod_nxt  = num;
        state_nxt = S_VAL;
      end
      S_VAL: begin
        res_nxt.value = prod_r[whs_pkg::FRAC_W +: 32] + 32'(round_up);
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      gen_r    <= 31'd1;
      count_r  <= '0;
      total_r  <= '0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      gen_r    <= gen_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cum_r  <= cum_nxt;
    prod_r <= prod_nxt;
    low_r  <= low_nxt;
    diff_r <= diff_nxt;
    op_r   <= op_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== design/whs_checker.sv =====
// ----------------------------------------------------------------------------
// whs_checker: port-level checks of the weighted histogram sampler
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module whs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // the result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // an accepted beat occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // busy drops only right after the result beat
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> $past(out_valid))
    else $error("busy dropped without a result");

endmodule

bind weighted_histogram_sampler whs_checker u_whs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== verif/weighted_histogram_sampler_test.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_sampler_test: self-checking bench for the bin sampler
// Fills the bin table with directed extremes, then runs phases of random
// beats under several generator seeds. Every result beat is checked field
// by field against an in-bench model of the table and the Lehmer generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weighted_histogram_sampler_test;

  localparam int          BINS        = 16;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          DRAIN_WAIT  = 32;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  whs_pkg::whs_in_t  in_data   = '0;
  logic              out_valid;
  whs_pkg::whs_out_t out_data;
  logic              cfg_we    = 1'b0;
  logic [30:0]       cfg_wdata = '0;

  whs_pkg::whs_in_t  beat_q[$];
  whs_pkg::whs_out_t result_q[$];
  logic     beat_taken = 1'b0;
  bit       drain_wait = 1'b0;
  int       idle_pct   = 19;
  int       mismatches = 0;
  int       cycle_count = 0;

  // model of the table and the generator
  logic [30:0]        model_gen;
  logic signed [31:0] tbl_low   [BINS];
  logic signed [31:0] tbl_high  [BINS];
  logic [15:0]        tbl_weight[BINS];
  int                 tbl_count;
  longint unsigned    tbl_total;

  weighted_histogram_sampler #(.BINS(BINS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // two lehmer steps, returns n in [2, 2^24]
  function automatic logic [24:0] lehmer_draw();
    longint unsigned z;
    z = 64'(model_gen);
    z = (z * whs_pkg::LEHMER_MUL_A) % whs_pkg::LEHMER_MOD;
    z = (z * whs_pkg::LEHMER_MUL_B) % whs_pkg::LEHMER_MOD;
    model_gen = z[30:0];
    return 25'(((z >> 7) | 64'd1) + 64'd1);
  endfunction

  function automatic logic [3:0] choose_bin();
    longint unsigned n;
    longint unsigned acc;
    n = 64'(lehmer_draw());
    acc = 0;
    for (int i = 0; i + 1 < tbl_count; i++) begin
      acc += 64'(tbl_weight[i]);
      if (n * tbl_total < (acc << whs_pkg::FRAC_W)) return 4'(i);
    end
    // nothing hit, or all weights zero: last bin
    return 4'(tbl_count - 1);
  endfunction

  function automatic whs_pkg::whs_out_t predict_beat(whs_pkg::whs_in_t b);
    whs_pkg::whs_out_t r;
    logic [3:0]        pick;
    longint            from;
    longint            diff;
    longint            num;
    r = '0;
    case (b.opcode)
      whs_pkg::OP_APPEND: begin
        if (tbl_count >= BINS) begin
          r.status = whs_pkg::ST_FULL;
        end else begin
          tbl_low[tbl_count]    = b.bin_low;
          tbl_high[tbl_count]   = b.bin_high;
          tbl_weight[tbl_count] = b.weight;
          tbl_total            += 64'(b.weight);
          r.bin_index           = 4'(tbl_count);
          tbl_count++;
        end
      end
      whs_pkg::OP_SAMPLE_REAL, whs_pkg::OP_SAMPLE_ENUM: begin
        if (tbl_count == 0) begin
          r.status = whs_pkg::ST_EMPTY;
        end else begin
          pick        = choose_bin();
          r.bin_index = pick;
          if (b.opcode == whs_pkg::OP_SAMPLE_ENUM) begin
            r.value = tbl_low[pick];
          end else begin
            from    = longint'(tbl_low[pick]);
            diff    = longint'(tbl_high[pick]) - from;
            num     = from * (longint'(1) << whs_pkg::FRAC_W) +
                      longint'(lehmer_draw()) * diff;
            r.value = 32'(num / (longint'(1) << whs_pkg::FRAC_W));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic whs_pkg::whs_in_t random_beat();
    whs_pkg::whs_in_t b;
    int               pick;
    pick       = $urandom_range(0, 99);
    b.opcode   = (pick < 45) ? whs_pkg::OP_SAMPLE_REAL :
                 (pick < 85) ? whs_pkg::OP_SAMPLE_ENUM :
                 (pick < 95) ? whs_pkg::OP_APPEND : OP_UNUSED;
    b.bin_low  = $urandom;
    b.bin_high = $urandom;
    b.weight   = 16'($urandom_range(0, 65535));
    return b;
  endfunction

  function automatic whs_pkg::whs_in_t make_beat(logic [1:0] op, logic [31:0] lo,
                                                 logic [31:0] hi, logic [15:0] w);
    whs_pkg::whs_in_t b;
    b.opcode   = op;
    b.bin_low  = lo;
    b.bin_high = hi;
    b.weight   = w;
    return b;
  endfunction

  task automatic queue_beat(whs_pkg::whs_in_t b);
    beat_q = {beat_q, b};
  endtask

  task automatic flag_mismatch(string what, whs_pkg::whs_out_t want,
                               whs_pkg::whs_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: want value %h bin %0d status %0d, got value %h bin %0d status %0d",
               $realtime, what, want.value, want.bin_index, want.status,
               got.value, got.bin_index, got.status);
  endtask

  // driver: a beat is held until taken, then the next is offered or start is dropped
  always @(negedge clk) begin
    if (drain_wait && result_q.size() == 0) drain_wait = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (!drain_wait && beat_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data <= beat_q.pop_front();
        start   <= 1'b1;
        if ($urandom_range(0, 79) == 0) drain_wait = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks result beats, predicts accepted ones
  always @(posedge clk) begin
    whs_pkg::whs_out_t want;
    if (!rst_n) begin
      model_gen  = 31'd1;
      tbl_count  = 0;
      tbl_total  = 0;
      beat_taken <= 1'b0;
    end else begin
      if (cfg_we) model_gen = cfg_wdata;
      if (out_valid) begin
        if (result_q.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, out_data);
        end else begin
          want = result_q.pop_front();
          if (out_data.value !== want.value || out_data.bin_index !== want.bin_index ||
              out_data.status !== want.status)
            flag_mismatch("result mismatch", want, out_data);
        end
      end
      if (start && !busy) result_q = {result_q, predict_beat(in_data)};
      beat_taken <= start && !busy;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic wait_idle();
    while (beat_q.size() != 0 || start || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_seed(logic [30:0] s);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = s;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [30:0] seed_plan[6];
    int          beat_plan[6];
    seed_plan = '{31'h7FFF_FFFE, 31'd0, 31'($urandom_range(1, 2147483646)),
                  31'h7FFF_FFFF, 31'($urandom_range(1, 2147483646)),
                  31'($urandom_range(1, 2147483646))};
    beat_plan = '{400, 40, 450, 40, 500, 520};

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    load_seed(31'd1);

    // empty table, unused opcode, then bins at the extremes
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_REAL, $urandom, $urandom, 16'($urandom)));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_ENUM, $urandom, $urandom, 16'($urandom)));
    queue_beat(make_beat(OP_UNUSED, $urandom, $urandom, 16'($urandom)));
    // widest range, zero weight: all-zero table falls to the last bin
    queue_beat(make_beat(whs_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_REAL, '0, '0, '0));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_ENUM, '0, '0, '0));
    // high below low, full weight
    queue_beat(make_beat(whs_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_REAL, '0, '0, '0));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_ENUM, '0, '0, '0));
    for (int i = 2; i < BINS; i++)
      queue_beat(make_beat(whs_pkg::OP_APPEND, $urandom, $urandom,
                           (i == 2) ? 16'd1 : (i == 3) ? 16'd0 :
                           16'($urandom_range(0, 65535))));
    // table full
    queue_beat(make_beat(whs_pkg::OP_APPEND, $urandom, $urandom, 16'($urandom)));
    queue_beat(make_beat(whs_pkg::OP_SAMPLE_REAL, '0, '0, '0));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      load_seed(seed_plan[p]);
      idle_pct = (p < 2) ? 19 : (p < 4) ? 72 : 0;
      for (int k = 0; k < beat_plan[p]; k++) queue_beat(random_beat());
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/whs_pkg.sv
design/whs_ram.sv
design/weighted_histogram_sampler.sv
design/whs_checker.sv
verif/weighted_histogram_sampler_test.sv
